### hw/rtl/nmh_pkg.sv
package nmh_pkg;

    // Field widths
    localparam int INDEX_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int N_STEPS      = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int STEP_W       = 5;
    localparam int SQRT_STEPS   = 32;

    localparam int REGION_W = 8;
    localparam int DATE_W   = 16;
    localparam int LAT_W    = 28;
    localparam int LON_W    = 29;
    localparam int BIDX_W   = 16;
    localparam int DIST_W   = 25;

    // Input tdata layout, lowest field first
    localparam int REGION_LSB = 0;
    localparam int DATE_LSB   = REGION_LSB + REGION_W;
    localparam int LAT_LSB    = DATE_LSB + DATE_W;
    localparam int LON_LSB    = LAT_LSB + LAT_W;
    localparam int IDX_LSB    = LON_LSB + LON_W;
    localparam int IN_BITS    = IDX_LSB + INDEX_BITS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_TDATA_W = ((BIDX_W + DIST_W + 7) / 8) * 8;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 29;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LAT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LON    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_DATE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_REGION = 2'd3;

    // Angle arithmetic (half-microdegrees, Q30 radians)
    localparam logic signed [31:0] HALF_H    = 32'sd360000000;
    localparam logic signed [31:0] FULL_H    = 32'sd720000000;
    localparam logic signed [31:0] QUARTER_H = 32'sd180000000;
    localparam logic [63:0] H_TO_RAD = 64'd40244552548;
    localparam int KSPLIT = 18;
    localparam logic signed [33:0] K_LO = 34'(H_TO_RAD % (64'd1 << KSPLIT));
    localparam logic signed [33:0] K_HI = 34'(H_TO_RAD >> KSPLIT);
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
    localparam logic signed [33:0] DIAM_M    = 34'sd12756200;
    localparam logic [DIST_W-1:0] DIST_MAX   = 25'd20037392;

    typedef logic signed [33:0] t_ang;

    // Datapath operations
    localparam logic [4:0] OP_NONE  = 5'd0;
    localparam logic [4:0] OP_LOAD  = 5'd1;
    localparam logic [4:0] OP_RED   = 5'd2;
    localparam logic [4:0] OP_MLO   = 5'd3;
    localparam logic [4:0] OP_MHI   = 5'd4;
    localparam logic [4:0] OP_ZSET  = 5'd5;
    localparam logic [4:0] OP_ROT   = 5'd6;
    localparam logic [4:0] OP_SAVE  = 5'd7;
    localparam logic [4:0] OP_SQ1   = 5'd8;
    localparam logic [4:0] OP_SQ2   = 5'd9;
    localparam logic [4:0] OP_CC    = 5'd10;
    localparam logic [4:0] OP_CCSQ  = 5'd11;
    localparam logic [4:0] OP_AINIT = 5'd12;
    localparam logic [4:0] OP_SQRT  = 5'd13;
    localparam logic [4:0] OP_VINIT = 5'd14;
    localparam logic [4:0] OP_VEC   = 5'd15;
    localparam logic [4:0] OP_DMUL  = 5'd16;
    localparam logic [4:0] OP_DIST  = 5'd17;
    localparam logic [4:0] OP_EMIT  = 5'd18;

    typedef struct packed {
        logic [4:0]        op;
        logic [1:0]        angle;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic last;
        logic out_full;
    } t_status;

    function automatic t_ang atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 34'sd843314856;
            5'd1:  atan_q30 = 34'sd497837829;
            5'd2:  atan_q30 = 34'sd263043836;
            5'd3:  atan_q30 = 34'sd133525158;
            5'd4:  atan_q30 = 34'sd67021686;
            5'd5:  atan_q30 = 34'sd33543515;
            5'd6:  atan_q30 = 34'sd16775850;
            5'd7:  atan_q30 = 34'sd8388437;
            5'd8:  atan_q30 = 34'sd4194282;
            5'd9:  atan_q30 = 34'sd2097149;
            5'd10: atan_q30 = 34'sd1048575;
            5'd11: atan_q30 = 34'sd524287;
            5'd12: atan_q30 = 34'sd262143;
            5'd13: atan_q30 = 34'sd131071;
            5'd14: atan_q30 = 34'sd65535;
            5'd15: atan_q30 = 34'sd32767;
            5'd16: atan_q30 = 34'sd16383;
            5'd17: atan_q30 = 34'sd8191;
            5'd18: atan_q30 = 34'sd4095;
            5'd19: atan_q30 = 34'sd2047;
            5'd20: atan_q30 = 34'sd1023;
            5'd21: atan_q30 = 34'sd511;
            5'd22: atan_q30 = 34'sd255;
            5'd23: atan_q30 = 34'sd127;
            5'd24: atan_q30 = 34'sd63;
            5'd25: atan_q30 = 34'sd31;
            5'd26: atan_q30 = 34'sd15;
            5'd27: atan_q30 = 34'sd8;
            5'd28: atan_q30 = 34'sd4;
            5'd29: atan_q30 = 34'sd2;
            5'd30: atan_q30 = 34'sd1;
            default: atan_q30 = 34'sd0;
        endcase
    endfunction

endpackage

### hw/rtl/nearest_match_haversine.sv
// A candidate whose date or region differs passes the check state and returns to idle; a
// matching one goes on through four 24-step CORDIC sine/cosine runs (each with angle reduction
// and the two-part radian multiply), a 32-step dual square root, a 24-step vectoring run and
// the squaring, product and distance steps. One candidate is taken at a time; a last candidate's
// result is valid as the block returns to idle, later if the previous result still waits. Reset
// (sync, active low) clears the control, query, search and output-valid registers.
module nearest_match_haversine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Candidate stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: cand_region, cand_date, cand_lat, cand_lon, cand_index (low bit up)
    input  logic [nmh_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tlast: last_cand
    input  logic                             i_s_axis_tlast,
    // Result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: best_index, best_distance_m (low bit up)
    output logic [nmh_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: match_found
    output logic                             o_m_axis_tuser,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nmh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nmh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nmh_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Configuration transfers are always taken
    assign o_cfg_ready = 1'b1;

    // Sequencer: walks each candidate through the shared arithmetic
    nmh_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    // Datapath: CORDIC unit, square roots, multiplier, best-match tracking, result register
    nmh_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

### hw/rtl/nmh_ctrl.sv
module nmh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  nmh_pkg::t_status i_status,
    output nmh_pkg::t_cmd    o_cmd
);
    import nmh_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_RED   = 5'd2;
    localparam logic [4:0] S_MLO   = 5'd3;
    localparam logic [4:0] S_MHI   = 5'd4;
    localparam logic [4:0] S_ZSET  = 5'd5;
    localparam logic [4:0] S_ROT   = 5'd6;
    localparam logic [4:0] S_SAVE  = 5'd7;
    localparam logic [4:0] S_SQ1   = 5'd8;
    localparam logic [4:0] S_SQ2   = 5'd9;
    localparam logic [4:0] S_CC    = 5'd10;
    localparam logic [4:0] S_CCSQ  = 5'd11;
    localparam logic [4:0] S_AINIT = 5'd12;
    localparam logic [4:0] S_SQRT  = 5'd13;
    localparam logic [4:0] S_VINIT = 5'd14;
    localparam logic [4:0] S_VEC   = 5'd15;
    localparam logic [4:0] S_DMUL  = 5'd16;
    localparam logic [4:0] S_DIST  = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;

    logic [4:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_angle, n_angle;
    logic              cordic_end, sqrt_end;

    assign cordic_end = (r_step == STEP_W'(N_STEPS - 1));
    assign sqrt_end   = (r_step == STEP_W'(SQRT_STEPS - 1));

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_angle     = r_angle;
        o_cmd.op    = OP_NONE;
        o_cmd.angle = r_angle;
        o_cmd.step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_angle = 2'd0;
                n_state = i_status.match ? S_RED : S_FIN;
            end
            S_RED: begin
                o_cmd.op = OP_RED;
                n_state  = S_MLO;
            end
            S_MLO: begin
                o_cmd.op = OP_MLO;
                n_state  = S_MHI;
            end
            S_MHI: begin
                o_cmd.op = OP_MHI;
                n_state  = S_ZSET;
            end
            S_ZSET: begin
                o_cmd.op = OP_ZSET;
                n_state  = S_ROT;
            end
            S_ROT: begin
                o_cmd.op = OP_ROT;
                if (cordic_end) begin
                    n_step  = '0;
                    n_state = S_SAVE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SAVE: begin
                o_cmd.op = OP_SAVE;
                if (r_angle == 2'd3) begin
                    n_state = S_SQ1;
                end else begin
                    n_angle = r_angle + 1'b1;
                    n_state = S_RED;
                end
            end
            S_SQ1: begin
                o_cmd.op = OP_SQ1;
                n_state  = S_SQ2;
            end
            S_SQ2: begin
                o_cmd.op = OP_SQ2;
                n_state  = S_CC;
            end
            S_CC: begin
                o_cmd.op = OP_CC;
                n_state  = S_CCSQ;
            end
            S_CCSQ: begin
                o_cmd.op = OP_CCSQ;
                n_state  = S_AINIT;
            end
            S_AINIT: begin
                o_cmd.op = OP_AINIT;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (sqrt_end) begin
                    n_step  = '0;
                    n_state = S_VINIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_VINIT: begin
                o_cmd.op = OP_VINIT;
                n_state  = S_VEC;
            end
            S_VEC: begin
                o_cmd.op = OP_VEC;
                if (cordic_end) begin
                    n_step  = '0;
                    n_state = S_DMUL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DMUL: begin
                o_cmd.op = OP_DMUL;
                n_state  = S_DIST;
            end
            S_DIST: begin
                o_cmd.op = OP_DIST;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (!i_status.out_full) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_angle <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_angle <= n_angle;
        end
    end

endmodule

### hw/rtl/nmh_datapath.sv
module nmh_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  nmh_pkg::t_cmd                    i_cmd,
    output nmh_pkg::t_status                 o_status,
    input  logic                             i_cfg_valid,
    input  logic [nmh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nmh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [nmh_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [nmh_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                             o_m_axis_tuser
);
    import nmh_pkg::*;

    // Query registers
    logic signed [LAT_W-1:0] r_qlat;
    logic signed [LON_W-1:0] r_qlon;
    logic [DATE_W-1:0]       r_qdate;
    logic [REGION_W-1:0]     r_qregion;

    // Candidate under work
    logic [REGION_W-1:0]     r_cregion;
    logic [DATE_W-1:0]       r_cdate;
    logic signed [LAT_W-1:0] r_clat;
    logic signed [LON_W-1:0] r_clon;
    logic [INDEX_BITS-1:0]   r_cidx;
    logic                    r_last;

    // Arithmetic state
    logic [LAT_W-1:0]   r_m;
    logic               r_neg, r_flip;
    logic signed [67:0] r_prod;
    logic [45:0]        r_plo;
    t_ang               r_x, r_y, r_z;
    t_ang               r_s1, r_s2, r_c1, r_c2, r_sq1, r_sq2;
    logic [63:0]        r_n1, r_n2, r_res1, r_res2, r_bit;

    // Search state and result register
    logic [DIST_W-1:0]     r_best_dist;
    logic [INDEX_BITS-1:0] r_best_idx;
    logic                  r_any;
    logic                  r_out_valid, r_out_match;
    logic [BIDX_W-1:0]     r_out_idx;
    logic [DIST_W-1:0]     r_out_dist;

    logic signed [31:0] h_sel, h_red, h_abs, h_fold;
    logic               red_neg, red_flip;
    t_ang               mul_a, mul_b;
    logic signed [67:0] mul_p, prod_sh, d_w;
    logic [63:0]        zsum, t1, t2;
    t_ang               dx, dy, at, zc;
    logic signed [35:0] a_sum;
    logic [30:0]        a_cl;
    logic [DIST_W-1:0]  d_sat;

    assign o_status.match    = (r_cregion == r_qregion) && (r_cdate == r_qdate);
    assign o_status.last     = r_last;
    assign o_status.out_full = r_out_valid;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_match;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_dist, r_out_idx});

    // Angle select and reduction into (-180, 180] degrees, then fold to [0, 90]
    always_comb begin
        case (i_cmd.angle)
            2'd0:    h_sel = 32'(r_clat) - 32'(r_qlat);
            2'd1:    h_sel = 32'(r_clon) - 32'(r_qlon);
            2'd2:    h_sel = 32'(r_qlat) + 32'(r_qlat);
            default: h_sel = 32'(r_clat) + 32'(r_clat);
        endcase
        if (h_sel > HALF_H) begin
            h_red = h_sel - FULL_H;
        end else if (h_sel <= -HALF_H) begin
            h_red = h_sel + FULL_H;
        end else begin
            h_red = h_sel;
        end
        red_neg  = h_red < 0;
        h_abs    = red_neg ? -h_red : h_red;
        red_flip = h_abs > QUARTER_H;
        h_fold   = red_flip ? (HALF_H - h_abs) : h_abs;
    end

    // Shared multiplier
    always_comb begin
        case (i_cmd.op)
            OP_MLO:  begin mul_a = t_ang'({6'd0, r_m}); mul_b = K_LO;   end
            OP_MHI:  begin mul_a = t_ang'({6'd0, r_m}); mul_b = K_HI;   end
            OP_SQ1:  begin mul_a = r_s1;                mul_b = r_s1;   end
            OP_SQ2:  begin mul_a = r_s2;                mul_b = r_s2;   end
            OP_CC:   begin mul_a = r_c1;                mul_b = r_c2;   end
            OP_CCSQ: begin mul_a = 34'(prod_sh);        mul_b = r_sq2;  end
            OP_DMUL: begin mul_a = zc;                  mul_b = DIAM_M; end
            default: begin mul_a = '0;                  mul_b = '0;     end
        endcase
    end
    assign mul_p   = mul_a * mul_b;
    assign prod_sh = r_prod >>> 30;

    assign zsum = {r_prod[45:0], 18'd0} + 64'(r_plo) + 64'h8000_0000;
    assign dx   = r_y >>> i_cmd.step;
    assign dy   = r_x >>> i_cmd.step;
    assign at   = atan_q30(i_cmd.step);
    assign zc   = (r_z < 0) ? '0 : r_z;

    always_comb begin
        a_sum = 36'(r_sq1) + 36'(prod_sh);
        if (a_sum < 0) begin
            a_cl = '0;
        end else if (a_sum > 36'(ONE_Q30)) begin
            a_cl = 31'(ONE_Q30);
        end else begin
            a_cl = a_sum[30:0];
        end
    end

    assign t1 = r_res1 + r_bit;
    assign t2 = r_res2 + r_bit;

    assign d_w   = (r_prod + 68'sd536870912) >>> 30;
    assign d_sat = (d_w > 68'(DIST_MAX)) ? DIST_MAX : d_w[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlat      <= '0;
            r_qlon      <= '0;
            r_qdate     <= '0;
            r_qregion   <= '0;
            r_best_dist <= '1;
            r_best_idx  <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_QUERY_LAT:    r_qlat    <= i_cfg_data[LAT_W-1:0];
                    REG_QUERY_LON:    r_qlon    <= i_cfg_data[LON_W-1:0];
                    REG_QUERY_DATE:   r_qdate   <= i_cfg_data[DATE_W-1:0];
                    REG_QUERY_REGION: r_qregion <= i_cfg_data[REGION_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_DIST: begin
                    if (d_sat < r_best_dist) begin
                        r_best_dist <= d_sat;
                        r_best_idx  <= r_cidx;
                    end
                    r_any <= 1'b1;
                end
                OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_best_dist <= '1;
                    r_best_idx  <= '0;
                    r_any       <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cregion <= i_s_axis_tdata[REGION_LSB +: REGION_W];
                r_cdate   <= i_s_axis_tdata[DATE_LSB +: DATE_W];
                r_clat    <= i_s_axis_tdata[LAT_LSB +: LAT_W];
                r_clon    <= i_s_axis_tdata[LON_LSB +: LON_W];
                r_cidx    <= i_s_axis_tdata[IDX_LSB +: INDEX_BITS];
                r_last    <= i_s_axis_tlast;
            end
            OP_RED: begin
                r_m    <= h_fold[LAT_W-1:0];
                r_neg  <= red_neg;
                r_flip <= red_flip;
            end
            OP_MLO: r_prod <= mul_p;
            OP_MHI: begin
                r_plo  <= r_prod[45:0];
                r_prod <= mul_p;
            end
            OP_ZSET: begin
                r_x <= CORDIC_X0;
                r_y <= '0;
                r_z <= t_ang'({2'd0, zsum[63:32]});
            end
            OP_ROT: begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
            end
            OP_SAVE: begin
                case (i_cmd.angle)
                    2'd0:    r_s1 <= r_neg ? -r_y : r_y;
                    2'd1:    r_s2 <= r_neg ? -r_y : r_y;
                    2'd2:    r_c1 <= r_flip ? -r_x : r_x;
                    default: r_c2 <= r_flip ? -r_x : r_x;
                endcase
            end
            OP_SQ1: r_prod <= mul_p;
            OP_SQ2: begin
                r_sq1  <= 34'(prod_sh);
                r_prod <= mul_p;
            end
            OP_CC: begin
                r_sq2  <= 34'(prod_sh);
                r_prod <= mul_p;
            end
            OP_CCSQ: r_prod <= mul_p;
            OP_AINIT: begin
                r_n1   <= {3'd0, a_cl, 30'd0};
                r_n2   <= {3'd0, 31'(ONE_Q30) - a_cl, 30'd0};
                r_res1 <= '0;
                r_res2 <= '0;
                r_bit  <= 64'd1 << 62;
            end
            OP_SQRT: begin
                if (r_n1 >= t1) begin
                    r_n1   <= r_n1 - t1;
                    r_res1 <= (r_res1 >> 1) + r_bit;
                end else begin
                    r_res1 <= r_res1 >> 1;
                end
                if (r_n2 >= t2) begin
                    r_n2   <= r_n2 - t2;
                    r_res2 <= (r_res2 >> 1) + r_bit;
                end else begin
                    r_res2 <= r_res2 >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_VINIT: begin
                r_x <= t_ang'(r_res2[33:0]);
                r_y <= t_ang'(r_res1[33:0]);
                r_z <= '0;
            end
            OP_VEC: begin
                if (r_y >= 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end
            end
            OP_DMUL: r_prod <= mul_p;
            OP_EMIT: begin
                r_out_match <= r_any;
                r_out_idx   <= r_any ? BIDX_W'(r_best_idx) : '0;
                r_out_dist  <= r_any ? r_best_dist : '0;
            end
            default: ;
        endcase
    end

endmodule

### hw/rtl/nmh_checker.sv
module nmh_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [nmh_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input logic                             i_s_axis_tlast,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [nmh_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                             o_m_axis_tuser,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [nmh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [nmh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nmh_pkg::*;

    logic in_xfer;
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_axis_tready)
        else $error("candidate taken while previous one in work");

    a_no_result_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_s_axis_tlast && !o_m_axis_tvalid) |=> !o_m_axis_tvalid)
        else $error("result without a last candidate");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("no-match result carries data");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[BIDX_W +: DIST_W] <= DIST_MAX))
        else $error("distance above half circumference");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind nearest_match_haversine nmh_checker u_nmh_checker (.*);
